// ----- rtl/core/ipt_pkg.sv -----
// Package for the inactivity power timers: item and configuration types,
// status codes, register indexes and the saturating counter step.
// No dependencies.
`default_nettype none

package ipt_pkg;

    localparam int COUNT_BITS       = 16;
    localparam int TICKS_PER_MINUTE = 120;
    // One extra bit so a zero-extended counter and any threshold sum compare cleanly
    localparam int CMP_BITS         = (COUNT_BITS > 16) ? COUNT_BITS + 1 : 17;
    localparam int CFG_IDX_BITS     = 3;
    localparam int CFG_DATA_BITS    = 8;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CMP_BITS-1:0]   thresh_t;

    // Backlight state codes
    localparam logic [1:0] BL_NORMAL = 2'd0;
    localparam logic [1:0] BL_DARK   = 2'd1;
    localparam logic [1:0] BL_OFF    = 2'd2;

    // Front application state codes
    localparam logic [1:0] APP_NO_PLAY   = 2'd0;
    localparam logic [1:0] APP_PLAYING   = 2'd1;
    localparam logic [1:0] APP_ALWAYS_ON = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_LIGHT_TIMEOUT     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAVER_TIMEOUT     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAVER_MODE        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DARK_OFF_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAVER_OFF_MINUTES = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_OFF_TIMEOUT  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLEEP_MINUTES     = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLAYING_TIMEOUT   = 3'd7;

    typedef struct packed {
        logic [1:0] bl_mode;
        logic       saver_active;
        logic       saver_is_screen_off;
        logic [1:0] front_app;
        logic       engine_playing;
        logic       cable_present;
    } in_item_t;

    typedef struct packed {
        logic dim_backlight;
        logic enter_saver;
        logic enter_screen_off;
        logic power_off;
        logic resume_play;
    } out_item_t;

    typedef struct packed {
        logic [7:0] light_timeout;
        logic [7:0] saver_timeout;
        logic [2:0] saver_mode;
        logic [7:0] dark_off_timeout;
        logic [7:0] saver_off_minutes;
        logic [7:0] idle_off_timeout;
        logic [7:0] sleep_minutes;
        logic [7:0] playing_timeout;
        thresh_t    dark_off_thresh;
        thresh_t    saver_off_thresh;
        thresh_t    sleep_thresh;
    } cfg_t;

    function automatic count_t sat_inc(count_t v);
        return (v == '1) ? v : v + count_t'(1);
    endfunction

    function automatic thresh_t widen(count_t v);
        return thresh_t'(v);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ipt_cfg.sv -----
// Configuration registers of the inactivity power timers and the derived
// compare thresholds. Depends on ipt_pkg.
`default_nettype none

module ipt_cfg
    import ipt_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output cfg_t                          cfg
);

    logic [7:0] light_timeout_reg;
    logic [7:0] saver_timeout_reg;
    logic [2:0] saver_mode_reg;
    logic [7:0] dark_off_timeout_reg;
    logic [7:0] saver_off_minutes_reg;
    logic [7:0] idle_off_timeout_reg;
    logic [7:0] sleep_minutes_reg;
    logic [7:0] playing_timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_timeout_reg     <= '0;
            saver_timeout_reg     <= '0;
            saver_mode_reg        <= '0;
            dark_off_timeout_reg  <= '0;
            saver_off_minutes_reg <= '0;
            idle_off_timeout_reg  <= '0;
            sleep_minutes_reg     <= '0;
            playing_timeout_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LIGHT_TIMEOUT:     light_timeout_reg     <= cfg_wdata;
                REG_SAVER_TIMEOUT:     saver_timeout_reg     <= cfg_wdata;
                REG_SAVER_MODE:        saver_mode_reg        <= cfg_wdata[2:0];
                REG_DARK_OFF_TIMEOUT:  dark_off_timeout_reg  <= cfg_wdata;
                REG_SAVER_OFF_MINUTES: saver_off_minutes_reg <= cfg_wdata;
                REG_IDLE_OFF_TIMEOUT:  idle_off_timeout_reg  <= cfg_wdata;
                REG_SLEEP_MINUTES:     sleep_minutes_reg     <= cfg_wdata;
                REG_PLAYING_TIMEOUT:   playing_timeout_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.light_timeout     = light_timeout_reg;
        cfg.saver_timeout     = saver_timeout_reg;
        cfg.saver_mode        = saver_mode_reg;
        cfg.dark_off_timeout  = dark_off_timeout_reg;
        cfg.saver_off_minutes = saver_off_minutes_reg;
        cfg.idle_off_timeout  = idle_off_timeout_reg;
        cfg.sleep_minutes     = sleep_minutes_reg;
        cfg.playing_timeout   = playing_timeout_reg;
        // Constant multiplies only; settled long before a tick arrives
        cfg.dark_off_thresh   = thresh_t'(light_timeout_reg) + thresh_t'(dark_off_timeout_reg);
        cfg.saver_off_thresh  = thresh_t'(saver_timeout_reg)
                              + thresh_t'(saver_off_minutes_reg) * thresh_t'(TICKS_PER_MINUTE);
        cfg.sleep_thresh      = thresh_t'(sleep_minutes_reg) * thresh_t'(TICKS_PER_MINUTE);
    end

endmodule

`default_nettype wire

// ----- rtl/core/ipt_timers.sv -----
// Timer state and per-tick update logic: counters, previous play states and
// the request flags for one tick. Depends on ipt_pkg.
`default_nettype none

module ipt_timers
    import ipt_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     advance,
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output out_item_t     result
);

    count_t     light_count_reg, light_count_next;
    count_t     saver_count_reg, saver_count_next;
    count_t     idle_count_reg,  idle_count_next;
    count_t     sleep_count_reg, sleep_count_next;
    count_t     play_count_reg,  play_count_next;
    logic       prev_engine_playing_reg;
    logic       prev_app_playing_reg;
    logic [7:0] prev_sleep_setting_reg;

    count_t     light_step;
    count_t     saver_step;
    logic       light_en, saver_en, dark_off_en, saver_off_en;
    logic       idle_en, sleep_en, play_en;
    logic       dark_now, stopped, no_play;

    always_comb begin
        result   = '0;
        no_play  = (item.front_app == APP_NO_PLAY) && !item.engine_playing;

        // Backlight dim; a dim this tick makes the backlight dark for the rest of it
        light_en   = (cfg.light_timeout != '0) && (item.bl_mode == BL_NORMAL)
                   && (item.front_app != APP_ALWAYS_ON);
        light_step = light_en ? sat_inc(light_count_reg) : light_count_reg;
        if (light_en && (widen(light_step) >= thresh_t'(cfg.light_timeout))) begin
            result.dim_backlight = 1'b1;
        end
        dark_now = result.dim_backlight || (item.bl_mode == BL_DARK);

        saver_en   = (cfg.saver_timeout != '0) && (cfg.saver_mode != '0)
                   && !item.saver_active && (item.front_app != APP_ALWAYS_ON);
        saver_step = saver_en ? sat_inc(saver_count_reg) : saver_count_reg;
        if (saver_en && (widen(saver_step) >= thresh_t'(cfg.saver_timeout))) begin
            result.enter_saver = 1'b1;
        end

        dark_off_en      = (cfg.dark_off_timeout != '0) && dark_now && (cfg.saver_mode == '0);
        light_count_next = dark_off_en ? sat_inc(light_step) : light_step;
        if (dark_off_en && (widen(light_count_next) >= cfg.dark_off_thresh)) begin
            result.enter_screen_off = 1'b1;
        end

        // A dimmed tick cannot be "off", so only the incoming state matters here
        saver_off_en     = (cfg.saver_off_minutes != '0) && item.saver_active
                         && !item.saver_is_screen_off
                         && (dark_now || (item.bl_mode != BL_OFF));
        saver_count_next = saver_off_en ? sat_inc(saver_step) : saver_step;
        if (saver_off_en && (widen(saver_count_next) >= cfg.saver_off_thresh)) begin
            result.enter_screen_off = 1'b1;
        end

        stopped = (prev_engine_playing_reg || prev_app_playing_reg) && no_play;

        idle_en         = (cfg.idle_off_timeout != '0) && !item.cable_present && no_play;
        idle_count_next = stopped ? '0 : idle_count_reg;
        if (idle_en) begin
            idle_count_next = sat_inc(idle_count_next);
            if (widen(idle_count_next) >= thresh_t'(cfg.idle_off_timeout)) begin
                result.power_off = 1'b1;
            end
        end

        sleep_en         = (cfg.sleep_minutes != '0) && !item.cable_present;
        sleep_count_next = ((cfg.sleep_minutes != '0)
                         && (cfg.sleep_minutes != prev_sleep_setting_reg)) ? '0 : sleep_count_reg;
        if (sleep_en) begin
            sleep_count_next = sat_inc(sleep_count_next);
            if (widen(sleep_count_next) >= cfg.sleep_thresh) begin
                result.power_off = 1'b1;
            end
        end

        play_en         = (cfg.playing_timeout != '0) && !item.saver_active
                        && item.engine_playing && (item.front_app == APP_NO_PLAY);
        play_count_next = stopped ? '0 : play_count_reg;
        if (play_en) begin
            play_count_next = sat_inc(play_count_next);
            if (widen(play_count_next) >= thresh_t'(cfg.playing_timeout)) begin
                result.resume_play = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_count_reg         <= '0;
            saver_count_reg         <= '0;
            idle_count_reg          <= '0;
            sleep_count_reg         <= '0;
            play_count_reg          <= '0;
            prev_engine_playing_reg <= 1'b0;
            prev_app_playing_reg    <= 1'b0;
            prev_sleep_setting_reg  <= '0;
        end else if (advance) begin
            light_count_reg         <= light_count_next;
            saver_count_reg         <= saver_count_next;
            idle_count_reg          <= idle_count_next;
            sleep_count_reg         <= sleep_count_next;
            play_count_reg          <= play_count_next;
            prev_engine_playing_reg <= item.engine_playing;
            prev_app_playing_reg    <= (item.front_app == APP_PLAYING);
            prev_sleep_setting_reg  <= cfg.sleep_minutes;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/inactivity_power_timers.sv -----
// Top level of the inactivity power timers: input register, timer update,
// result register and configuration port. Depends on ipt_pkg, ipt_cfg, ipt_timers.
`default_nettype none

// One tick transaction per half second carries the system status; each one
// yields exactly one result transaction with the five request flags. The block
// takes a new tick every clock cycle unless both registers are full; a result
// is registered after its tick is accepted (the tick sits in the input register,
// all timers update in a single pass, and the flags land in the result register
// once it is free or being read). A waiting result does not block the input side
// until both registers are full. Configuration writes take effect at once and
// belong in idle periods between ticks.
module inactivity_power_timers
    import ipt_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire in_item_t                 s_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output out_item_t                     m_data,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      advance;
    out_item_t result;
    cfg_t      cfg;

    ipt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ipt_timers u_timers (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Move the held tick into the result register when that slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with a free slot");

    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed tick produced no result");

    a_dim_needs_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result.dim_backlight) |-> (cfg.light_timeout != '0))
        else $error("dim request with backlight timer disabled");

    a_poff_needs_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result.power_off)
            |-> ((cfg.idle_off_timeout != '0) || (cfg.sleep_minutes != '0)))
        else $error("power off request with both timers disabled");
`endif

endmodule

`default_nettype wire

// ----- bench/timer_request_checker.sv -----
`timescale 1ns / 100ps
// Checker for the inactivity power timers: watches the tick, result and register ports,
// predicts the request flags of every accepted tick and compares them in order.
// Depends on ipt_pkg.
module timer_request_checker
    import ipt_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    input  wire logic                     s_ready,
    input  in_item_t                      s_data,
    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  out_item_t                     m_data,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output int                            fail_count,
    output int                            pending,
    output int                            checked
);

    logic [7:0] light_to, saver_to, dark_to, saver_off_min, idle_to, sleep_min, play_to;
    logic [7:0] last_sleep;
    logic [2:0] saver_sel;
    count_t     light_cnt, saver_cnt, idle_cnt, sleep_cnt, play_cnt;
    logic       was_engine, was_app_playing;
    out_item_t  expected_flags[$];
    out_item_t  want;
    int         errs = 0;
    int         seen = 0;

    function automatic count_t step_count(count_t v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Advance the timer copies by one tick and return the flags it raises.
    function automatic out_item_t predict_requests(in_item_t t);
        out_item_t  r;
        logic [1:0] bl;
        logic [1:0] app;
        logic       stopped;
        r   = '0;
        bl  = t.bl_mode;
        app = t.front_app;

        if (light_to != 0 && bl == BL_NORMAL && app != APP_ALWAYS_ON) begin
            light_cnt = step_count(light_cnt);
            if (int'(light_cnt) >= int'(light_to)) begin
                r.dim_backlight = 1'b1;
                bl = BL_DARK;   // rest of this tick sees the dimmed backlight
            end
        end

        if (saver_to != 0 && saver_sel != 0 && !t.saver_active && app != APP_ALWAYS_ON) begin
            saver_cnt = step_count(saver_cnt);
            if (int'(saver_cnt) >= int'(saver_to))
                r.enter_saver = 1'b1;
        end

        if (dark_to != 0 && bl == BL_DARK && saver_sel == 0) begin
            light_cnt = step_count(light_cnt);
            if (int'(light_cnt) >= int'(light_to) + int'(dark_to))
                r.enter_screen_off = 1'b1;
        end

        if (saver_off_min != 0 && t.saver_active && !t.saver_is_screen_off && bl != BL_OFF) begin
            saver_cnt = step_count(saver_cnt);
            if (int'(saver_cnt) >= int'(saver_to) + int'(saver_off_min) * TICKS_PER_MINUTE)
                r.enter_screen_off = 1'b1;
        end

        stopped = (was_engine || was_app_playing) && !t.engine_playing && app == APP_NO_PLAY;

        if (stopped)
            idle_cnt = '0;
        if (idle_to != 0 && !t.cable_present && !t.engine_playing && app == APP_NO_PLAY) begin
            idle_cnt = step_count(idle_cnt);
            if (int'(idle_cnt) >= int'(idle_to))
                r.power_off = 1'b1;
        end

        // A new sleep setting restarts the sleep timer.
        if (sleep_min != 0 && sleep_min != last_sleep)
            sleep_cnt = '0;
        if (sleep_min != 0 && !t.cable_present) begin
            sleep_cnt = step_count(sleep_cnt);
            if (int'(sleep_cnt) >= int'(sleep_min) * TICKS_PER_MINUTE)
                r.power_off = 1'b1;
        end

        if (stopped)
            play_cnt = '0;
        if (play_to != 0 && !t.saver_active && t.engine_playing && app == APP_NO_PLAY) begin
            play_cnt = step_count(play_cnt);
            if (int'(play_cnt) >= int'(play_to))
                r.resume_play = 1'b1;
        end

        was_engine      = t.engine_playing;
        was_app_playing = (app == APP_PLAYING);
        last_sleep      = sleep_min;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            light_to = '0; saver_to = '0; saver_sel = '0; dark_to = '0;
            saver_off_min = '0; idle_to = '0; sleep_min = '0; play_to = '0;
            light_cnt = '0; saver_cnt = '0; idle_cnt = '0; sleep_cnt = '0; play_cnt = '0;
            was_engine = 1'b0; was_app_playing = 1'b0; last_sleep = '0;
            expected_flags.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_LIGHT_TIMEOUT:     light_to      = cfg_wdata;
                    REG_SAVER_TIMEOUT:     saver_to      = cfg_wdata;
                    REG_SAVER_MODE:        saver_sel     = cfg_wdata[2:0];
                    REG_DARK_OFF_TIMEOUT:  dark_to       = cfg_wdata;
                    REG_SAVER_OFF_MINUTES: saver_off_min = cfg_wdata;
                    REG_IDLE_OFF_TIMEOUT:  idle_to       = cfg_wdata;
                    REG_SLEEP_MINUTES:     sleep_min     = cfg_wdata;
                    REG_PLAYING_TIMEOUT:   play_to       = cfg_wdata;
                    default: ;
                endcase
            end

            // Retire the result before queueing a new tick, so a stray result is caught.
            if (m_valid && m_ready) begin
                if (expected_flags.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: result with no tick pending: %b", $time, m_data);
                end else begin
                    want = expected_flags.pop_front();
                    seen++;
                    if (m_data.dim_backlight    !== want.dim_backlight    ||
                        m_data.enter_saver      !== want.enter_saver      ||
                        m_data.enter_screen_off !== want.enter_screen_off ||
                        m_data.power_off        !== want.power_off        ||
                        m_data.resume_play      !== want.resume_play) begin
                        errs++;
                        if (errs <= 10)
                            $display({"%0t: result %0d expected dim=%b saver=%b off=%b ",
                                      "poff=%b back=%b, got dim=%b saver=%b off=%b ",
                                      "poff=%b back=%b"}, $time, seen,
                                     want.dim_backlight, want.enter_saver,
                                     want.enter_screen_off, want.power_off,
                                     want.resume_play, m_data.dim_backlight,
                                     m_data.enter_saver, m_data.enter_screen_off,
                                     m_data.power_off, m_data.resume_play);
                    end
                end
            end

            if (s_valid && s_ready)
                expected_flags.push_back(predict_requests(s_data));
        end
        fail_count <= errs;
        pending    <= expected_flags.size();
        checked    <= seen;
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the inactivity power timers bench: clock, reset, tick stimulus, register
// settings and verdict. Depends on ipt_pkg, inactivity_power_timers, timer_request_checker.
module tb_top
    import ipt_pkg::*;
();

    localparam int         CYCLE_LIMIT   = 200000;
    localparam logic [1:0] BL_UNDEFINED  = 2'd3;
    localparam logic [1:0] APP_UNDEFINED = 2'd3;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    in_item_t                 s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    out_item_t                m_data;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = REG_LIGHT_TIMEOUT;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    int       fail_count, pending, checked;
    int       tx_gap_pct    = 0;
    int       rx_stall_pct  = 0;
    int       ticks_sent    = 0;
    int       settings_used = 0;
    int       cycle_count   = 0;
    in_item_t status        = '0;

    always #10 aclk = ~aclk;

    inactivity_power_timers uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    timer_request_checker req_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic in_item_t tick_of(logic [1:0] bl, logic sa, logic so,
                                         logic [1:0] app, logic eng, logic cab);
        in_item_t t;
        t.bl_mode             = bl;
        t.saver_active        = sa;
        t.saver_is_screen_off = so;
        t.front_app           = app;
        t.engine_playing      = eng;
        t.cable_present       = cab;
        return t;
    endfunction

    function automatic logic [1:0] pick_backlight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)      return BL_NORMAL;
        else if (r < 78) return BL_DARK;
        else if (r < 94) return BL_OFF;
        else             return BL_UNDEFINED;
    endfunction

    function automatic logic [1:0] pick_app();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)      return APP_NO_PLAY;
        else if (r < 70) return APP_PLAYING;
        else if (r < 90) return APP_ALWAYS_ON;
        else             return APP_UNDEFINED;
    endfunction

    // Hold the status mostly steady so timers can run out; now and then throw noise.
    function automatic in_item_t drift(in_item_t cur);
        in_item_t t;
        t = cur;
        if ($urandom_range(0, 9) == 0)
            return in_item_t'(8'($urandom));
        if ($urandom_range(0, 5) == 0) t.bl_mode             = pick_backlight();
        if ($urandom_range(0, 5) == 0) t.saver_active        = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 5) == 0) t.saver_is_screen_off = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 5) == 0) t.front_app           = pick_app();
        if ($urandom_range(0, 5) == 0) t.engine_playing      = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 5) == 0) t.cable_present       = ($urandom_range(0, 4) == 0);
        return t;
    endfunction

    task automatic send_tick(input in_item_t t);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    // Drop valid and wait until every result is back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic write_config(input logic [7:0] lt, input logic [7:0] st,
                                input logic [7:0] md, input logic [7:0] dt,
                                input logic [7:0] sm, input logic [7:0] it,
                                input logic [7:0] sl, input logic [7:0] pt);
        cfg_we <= 1'b1;
        put_reg(REG_LIGHT_TIMEOUT, lt);
        put_reg(REG_SAVER_TIMEOUT, st);
        put_reg(REG_SAVER_MODE, md);
        put_reg(REG_DARK_OFF_TIMEOUT, dt);
        put_reg(REG_SAVER_OFF_MINUTES, sm);
        put_reg(REG_IDLE_OFF_TIMEOUT, it);
        put_reg(REG_SLEEP_MINUTES, sl);
        put_reg(REG_PLAYING_TIMEOUT, pt);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int n);
        repeat (n) begin
            status = drift(status);
            send_tick(status);
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        tx_gap_pct   = 17;
        rx_stall_pct = 53;

        // Reset settings: every timer disabled, no flag may rise.
        settings_used = 1;
        send_tick(tick_of(BL_NORMAL, 1'b0, 1'b0, APP_NO_PLAY, 1'b0, 1'b0));
        send_tick(in_item_t'('1));
        send_tick(tick_of(BL_DARK, 1'b1, 1'b0, APP_PLAYING, 1'b1, 1'b0));
        drain();

        write_config(8'd3, 8'd4, 8'd0, 8'd2, 8'd1, 8'd5, 8'd1, 8'd3);
        // Dim on the third tick; the dark-off timer counts on the same tick.
        repeat (4) send_tick(tick_of(BL_NORMAL, 1'b0, 1'b0, APP_NO_PLAY, 1'b0, 1'b0));
        send_tick(tick_of(BL_DARK, 1'b0, 1'b0, APP_NO_PLAY, 1'b0, 1'b0));
        send_tick(tick_of(BL_OFF, 1'b0, 1'b0, APP_NO_PLAY, 1'b0, 1'b0));
        send_tick(tick_of(BL_UNDEFINED, 1'b0, 1'b0, APP_NO_PLAY, 1'b0, 1'b0));
        send_tick(tick_of(BL_NORMAL, 1'b1, 1'b0, APP_NO_PLAY, 1'b0, 1'b0));
        send_tick(tick_of(BL_NORMAL, 1'b1, 1'b1, APP_NO_PLAY, 1'b0, 1'b0));
        // Play in the app, then stop: idle and playing timers restart.
        send_tick(tick_of(BL_NORMAL, 1'b0, 1'b0, APP_PLAYING, 1'b0, 1'b0));
        send_tick(tick_of(BL_NORMAL, 1'b0, 1'b0, APP_NO_PLAY, 1'b0, 1'b0));
        repeat (4) send_tick(tick_of(BL_DARK, 1'b0, 1'b0, APP_NO_PLAY, 1'b1, 1'b0));
        send_tick(tick_of(BL_DARK, 1'b0, 1'b0, APP_NO_PLAY, 1'b0, 1'b0));
        send_tick(tick_of(BL_NORMAL, 1'b0, 1'b0, APP_ALWAYS_ON, 1'b0, 1'b0));
        send_tick(tick_of(BL_NORMAL, 1'b0, 1'b0, APP_UNDEFINED, 1'b1, 1'b0));
        send_tick(tick_of(BL_NORMAL, 1'b0, 1'b0, APP_NO_PLAY, 1'b0, 1'b1));
        send_tick(in_item_t'('1));
        send_tick(in_item_t'('0));
        run_random(130);

        tx_gap_pct   = 53;
        rx_stall_pct = 17;
        write_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_random(60);
        write_config(8'd2, 8'd3, 8'd1, 8'd0, 8'd1, 8'd4, 8'd2, 8'd2);
        run_random(60);
        write_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_random(30);

        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        repeat (3) begin
            write_config(8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 12)),
                         8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                         8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)));
            run_random(55);
        end
        repeat (8) @(posedge aclk);

        $display("Covered %0d ticks under %0d register settings, %0d results compared.",
                 ticks_sent, settings_used, checked);
        $display("Mismatches: %0d, results still outstanding: %0d.", fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
